FILE: hw/rtl/tsg_pkg.sv
package tsg_pkg;

	// result status carried on the output tuser
	typedef enum logic [1:0] {
		ST_ISSUED    = 2'd0,
		ST_BEHIND    = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic [2:0] REG_DC_BITS  = 3'd0;
	localparam logic [2:0] REG_WK_BITS  = 3'd1;
	localparam logic [2:0] REG_SQ_BITS  = 3'd2;
	localparam logic [2:0] REG_TS_BITS  = 3'd3;
	localparam logic [2:0] REG_DC_IDENT = 3'd4;
	localparam logic [2:0] REG_WK_IDENT = 3'd5;
	localparam logic [2:0] REG_REV_DC   = 3'd6;

	localparam logic [4:0] MAX_FIELD_BITS = 5'd16;
	localparam logic [4:0] MAX_SEQ_BITS   = 5'd22;

	typedef struct packed {
		logic [4:0]  dc_bits;
		logic [4:0]  wk_bits;
		logic [4:0]  sq_bits;
		logic [5:0]  ts_bits;
		logic [15:0] dc_ident;
		logic [15:0] wk_ident;
		logic        rev_dc;
	} cfg_t;

	// decision for one request
	typedef struct packed {
		status_t     status;
		logic [22:0] seq;
	} dec_t;

endpackage

FILE: hw/rtl/tsg_cfg.sv
module tsg_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [2:0]     wr_addr,
	input  logic [15:0]    wr_data,
	output tsg_pkg::cfg_t  cfg
);

	tsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_bits  <= 5'd5;
			cfg_q.wk_bits  <= 5'd5;
			cfg_q.sq_bits  <= 5'd12;
			cfg_q.ts_bits  <= 6'd41;
			cfg_q.dc_ident <= 16'd0;
			cfg_q.wk_ident <= 16'd0;
			cfg_q.rev_dc   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_addr)
				tsg_pkg::REG_DC_BITS:  cfg_q.dc_bits  <= wr_data[4:0];
				tsg_pkg::REG_WK_BITS:  cfg_q.wk_bits  <= wr_data[4:0];
				tsg_pkg::REG_SQ_BITS:  cfg_q.sq_bits  <= wr_data[4:0];
				tsg_pkg::REG_TS_BITS:  cfg_q.ts_bits  <= wr_data[5:0];
				tsg_pkg::REG_DC_IDENT: cfg_q.dc_ident <= wr_data;
				tsg_pkg::REG_WK_IDENT: cfg_q.wk_ident <= wr_data;
				tsg_pkg::REG_REV_DC:   cfg_q.rev_dc   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/tsg_seq.sv
module tsg_seq #(
	parameter int TIME_WIDTH = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic [4:0]            sq_bits,
	output tsg_pkg::dec_t         dec
);

	logic [TIME_WIDTH-1:0] last_time_q;
	logic [22:0]           next_seq_q;
	logic [4:0]            sqw;
	logic [22:0]           seq_max;
	logic                  newer;
	logic                  behind;
	logic                  exhausted;
	logic [22:0]           eff_seq;

	always_comb begin
		sqw       = (sq_bits > tsg_pkg::MAX_SEQ_BITS) ? tsg_pkg::MAX_SEQ_BITS : sq_bits;
		seq_max   = ~({23{1'b1}} << sqw);
		newer     = now > last_time_q;
		behind    = now < last_time_q;
		// a newer timestamp restarts the sequence
		eff_seq   = newer ? 23'd0 : next_seq_q;
		exhausted = eff_seq > seq_max;
		dec.seq   = eff_seq;
		if (behind) begin
			dec.status = tsg_pkg::ST_BEHIND;
		end else if (exhausted) begin
			dec.status = tsg_pkg::ST_EXHAUSTED;
		end else begin
			dec.status = tsg_pkg::ST_ISSUED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			next_seq_q  <= '0;
		end else if (upd && !behind) begin
			if (newer) begin
				last_time_q <= now;
			end
			next_seq_q <= exhausted ? eff_seq : eff_seq + 23'd1;
		end
	end

endmodule

FILE: hw/rtl/tsg_compose.sv
module tsg_compose #(
	parameter int TIME_WIDTH = 63
) (
	input  logic [TIME_WIDTH-1:0] now,
	input  logic [21:0]           seq,
	input  tsg_pkg::cfg_t         cfg,
	output logic [62:0]           id
);

	function automatic logic [15:0] low_mask16(input logic [4:0] w);
		logic [31:0] m;
		m = ~({32{1'b1}} << w);
		return m[15:0];
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15-i];
		end
		return r;
	endfunction

	logic [4:0]  dcw;
	logic [4:0]  wkw;
	logic [4:0]  sqw;
	logic [5:0]  shamt;
	logic [15:0] dc_m;
	logic [15:0] dc_rev;
	logic [15:0] dc_sel;
	logic [15:0] wk_m;
	logic [63:0] ts_mask;
	logic [63:0] ts;
	logic [63:0] mid;
	logic [63:0] id64;

	always_comb begin
		dcw   = (cfg.dc_bits > tsg_pkg::MAX_FIELD_BITS) ? tsg_pkg::MAX_FIELD_BITS : cfg.dc_bits;
		wkw   = (cfg.wk_bits > tsg_pkg::MAX_FIELD_BITS) ? tsg_pkg::MAX_FIELD_BITS : cfg.wk_bits;
		sqw   = (cfg.sq_bits > tsg_pkg::MAX_SEQ_BITS) ? tsg_pkg::MAX_SEQ_BITS : cfg.sq_bits;
		shamt = {1'b0, sqw} + {1'b0, wkw} + {1'b0, dcw};
		dc_m  = cfg.dc_ident & low_mask16(dcw);
		wk_m  = cfg.wk_ident & low_mask16(wkw);
		// reverse all 16 bits, then slide the field back down to its width
		dc_rev  = rev16(dc_m) >> (tsg_pkg::MAX_FIELD_BITS - dcw);
		dc_sel  = cfg.rev_dc ? dc_rev : dc_m;
		ts_mask = ~({64{1'b1}} << cfg.ts_bits);
		ts      = {{(64-TIME_WIDTH){1'b0}}, now} & ts_mask;
		mid     = ({48'd0, dc_sel} << wkw) | {48'd0, wk_m};
		id64    = (ts << shamt) | (mid << sqw) | {42'd0, seq};
		id      = id64[62:0];
	end

endmodule

FILE: hw/rtl/timestamp_sequence_id_generator.sv
// timestamp and sequence ID generator
//
// input stream (s_*): one word per ID request, s_tdata[62:0] = current time.
// output stream (m_*): one word per request, m_tdata[62:0] = ID, m_tuser =
//   status (issued, clock behind, sequence exhausted); the ID is zero unless
//   the status is issued, and a refused requester simply retries later.
// config channel (cfg_*): register index on cfg_addr, value on cfg_data;
//   always ready, to be written while no request is in flight.
// an accepted word passes the input register, then the output register.
// throughput: one word per cycle while m_tready is high; the loop that sets
//   it is the compare of time against last time and the sequence increment.
// the input register and the output register decouple both sides, so a new
//   request is taken while an earlier result waits; when m_tready is low the
//   result holds and s_tready drops only once both registers are full.
// reset clears the last time and sequence to zero, loads the register
//   defaults (5/5/12/41 bit fields, zero identifiers, no reversal) and empties
//   the pipeline.
module timestamp_sequence_id_generator #(
	parameter int TIME_WIDTH = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [62:0] now_time, [63] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [62:0] id_value, [63] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data
);

	tsg_pkg::cfg_t   cfg;
	tsg_pkg::dec_t   dec;
	tsg_pkg::status_t status_s2;

	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  valid_s2;
	logic [62:0]           id_s2;
	logic [62:0]           id;
	logic                  adv;

	assign cfg_ready = 1'b1;

	// stage 1 moves on whenever the output register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	tsg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// state commits only when the word leaves stage 1
	tsg_seq #(.TIME_WIDTH(TIME_WIDTH)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (adv),
		.now     (now_s1),
		.sq_bits (cfg.sq_bits),
		.dec     (dec)
	);

	tsg_compose #(.TIME_WIDTH(TIME_WIDTH)) u_compose (
		.now (now_s1),
		.seq (dec.seq[21:0]),
		.cfg (cfg),
		.id  (id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1 <= s_tdata[TIME_WIDTH-1:0];
		end
		if (adv) begin
			status_s2 <= dec.status;
			id_s2     <= (dec.status == tsg_pkg::ST_ISSUED) ? id : 63'd0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, id_s2};
	assign m_tuser  = status_s2;

	// a refused request never carries an ID
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != tsg_pkg::ST_ISSUED |-> id_s2 == 63'd0)
		else $error("refused request carries a nonzero id");

	// an issued sequence number always fits the widest sequence field
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dec.status == tsg_pkg::ST_ISSUED |-> dec.seq[22] == 1'b0)
		else $error("issued sequence number out of range");

	// an empty output register never blocks the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty output register");

	// every word leaving stage 1 lands in the output register
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced word lost");

endmodule
